### sv/coltr_pkg.sv
// ----------------------------------------------------------------------------
// coltr_pkg
// Shared types and constants for the columnar transposition block.
// ----------------------------------------------------------------------------
package coltr_pkg;

    localparam int COL_W = 5;
    localparam int STAT_W = 2;
    localparam logic [7:0] PAD_BYTE = 8'h24;

    localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_COLS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_CHECK = 6'b000010,
        S_DIV   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_FLAG  = 6'b100000
    } state_t;

endpackage

### sv/columnar_transposition.sv
// ----------------------------------------------------------------------------
// columnar_transposition
// Unkeyed columnar transposition of one message held in a small byte store.
// ----------------------------------------------------------------------------
// Input stream: one text byte per transfer, tlast on the final byte of the
// message. Bytes are taken one per cycle while the block is loading; bytes past
// MAX_LEN are dropped and the message ends with an overflow result.
// After the final byte the block stops taking input. A check state follows,
// then a repeated-subtract divider. Encrypt pads with '$' to whole rows and
// reads column by column; decrypt reads at stride length / column_count, first
// scanning the read order once (one byte per cycle) to find the last byte that
// is not '$'. The first result is registered after the check, divide and
// emit states in encrypt mode, after the scan as well in decrypt mode; an error
// result is registered from the flag state after the check. Results follow one
// per cycle from the output register while the output is not stalled; encrypt
// gives length rounded up to whole rows (at most 2 * length - 2). Input is
// taken again once the last result is registered. Errors and empty results give
// one transfer with tuser.has_char low and tlast high. A stall on the output
// side holds the output register and pauses the read sequencer; nothing is
// lost. Reset clears the store length, selects encrypt and two columns.
// Registers: mode at 0x0, column_count at 0x4.
// ----------------------------------------------------------------------------
module columnar_transposition
    import coltr_pkg::*;
#(
    parameter int MAX_LEN = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] text_byte
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]        m_axis_tuser,   // [0] has_char, [2:1] status
    output logic              m_axis_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int IW = $clog2(2 * MAX_LEN);
    localparam int XW = $clog2(MAX_LEN);
    localparam int WW = ((IW > COL_W) ? IW : COL_W) + 1;

    logic [7:0]         store_mem [MAX_LEN];
    logic [7:0]         rd_byte_reg;

    state_t             state_reg, state_next;
    logic               mode_reg;
    logic [COL_W-1:0]   cols_reg;
    logic [LW-1:0]      len_reg, len_next;
    logic               ovf_reg, ovf_next;
    logic [LW-1:0]      rem_reg, rem_next;
    logic [COL_W-1:0]   quo_reg, quo_next;
    logic [COL_W-1:0]   stride_reg, stride_next;
    logic [IW-1:0]      limit_reg, limit_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [IW-1:0]      pos_reg, pos_next;
    logic [IW-1:0]      cnt_reg, cnt_next;
    logic [IW-1:0]      lastidx_reg, lastidx_next;
    logic               found_reg, found_next;
    logic [STAT_W-1:0]  flag_stat_reg, flag_stat_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_has_reg, out_has_next;
    logic               out_last_reg, out_last_next;
    logic [STAT_W-1:0]  out_stat_reg, out_stat_next;

    logic               in_xfer;
    logic               cfg_wr;
    logic               slot_free;
    logic [7:0]         cur_byte;
    logic [WW-1:0]      pos_sum;
    logic               col_wrap;
    logic               seq_end;
    logic [IW-1:0]      pos_adv;
    logic [COL_W-1:0]   col_adv;
    logic               cur_pad;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            REG_MODE: prdata = {31'd0, mode_reg};
            REG_COLS: prdata = {{(32-COL_W){1'b0}}, cols_reg};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENC;
            cols_reg <= COL_W'(2);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_MODE)
                mode_reg <= pwdata[0];
            else
                cols_reg <= pwdata[COL_W-1:0];
        end
    end

    assign s_axis_tready = (state_reg == S_LOAD);
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign slot_free = !out_valid_reg || m_axis_tready;

    // read data follows pos_reg: the address is the position taken at the same edge
    always_ff @(posedge clk)
    begin
        if (in_xfer && (len_reg < LW'(MAX_LEN)))
            store_mem[len_reg[XW-1:0]] <= s_axis_tdata;
        rd_byte_reg <= store_mem[pos_next[XW-1:0]];
    end

    // read sequencer position
    assign cur_byte = (WW'(pos_reg) < WW'(len_reg)) ? rd_byte_reg : PAD_BYTE;
    assign cur_pad  = (cur_byte == PAD_BYTE);
    assign pos_sum  = WW'(pos_reg) + WW'(stride_reg);
    assign col_wrap = (pos_sum >= WW'(limit_reg));
    assign seq_end  = col_wrap && (WW'(col_reg) + WW'(1) == WW'(stride_reg));
    assign col_adv  = col_wrap ? col_reg + COL_W'(1) : col_reg;
    assign pos_adv  = col_wrap ? IW'(col_reg + COL_W'(1)) : pos_sum[IW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        stride_next    = stride_reg;
        limit_next     = limit_reg;
        col_next       = col_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        lastidx_next   = lastidx_reg;
        found_next     = found_reg;
        flag_stat_next = flag_stat_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        out_stat_next  = out_stat_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (in_xfer)
                begin
                    if (len_reg < LW'(MAX_LEN))
                        len_next = len_reg + LW'(1);
                    else
                        ovf_next = 1'b1;
                    if (s_axis_tlast)
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                rem_next = len_reg;
                quo_next = '0;
                if (ovf_reg)
                begin
                    flag_stat_next = STAT_OVERFLOW;
                    state_next = S_FLAG;
                end
                else if ((cols_reg < COL_W'(2)) || (WW'(cols_reg) >= WW'(len_reg)))
                begin
                    flag_stat_next = STAT_BAD_COLS;
                    state_next = S_FLAG;
                end
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (WW'(rem_reg) >= WW'(cols_reg))
                begin
                    rem_next = LW'(WW'(rem_reg) - WW'(cols_reg));
                    quo_next = quo_reg + COL_W'(1);
                end
                else
                begin
                    col_next   = '0;
                    pos_next   = '0;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    if (mode_reg == MODE_ENC)
                    begin
                        stride_next = cols_reg;
                        if (rem_reg != '0)
                            limit_next = IW'(WW'(len_reg) + WW'(cols_reg) - WW'(rem_reg));
                        else
                            limit_next = IW'(len_reg);
                        lastidx_next = limit_next - IW'(1);
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        stride_next = quo_reg;
                        limit_next  = IW'(len_reg);
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (!cur_pad)
                begin
                    lastidx_next = cnt_reg;
                    found_next   = 1'b1;
                end
                if (seq_end)
                begin
                    col_next = '0;
                    pos_next = '0;
                    cnt_next = '0;
                    if (found_reg || !cur_pad)
                        state_next = S_EMIT;
                    else
                    begin
                        flag_stat_next = STAT_OK;
                        state_next = S_FLAG;
                    end
                end
                else
                begin
                    col_next = col_adv;
                    pos_next = pos_adv;
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = cur_byte;
                    out_has_next   = 1'b1;
                    out_last_next  = (cnt_reg == lastidx_reg);
                    out_stat_next  = STAT_OK;
                    if (cnt_reg == lastidx_reg)
                    begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        col_next = col_adv;
                        pos_next = pos_adv;
                        cnt_next = cnt_reg + IW'(1);
                    end
                end
            end
            S_FLAG:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_has_next   = 1'b0;
                    out_last_next  = 1'b1;
                    out_stat_next  = flag_stat_reg;
                    len_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            stride_reg    <= '0;
            limit_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            stride_reg    <= stride_next;
            limit_reg     <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        col_reg       <= col_next;
        pos_reg       <= pos_next;
        cnt_reg       <= cnt_next;
        lastidx_reg   <= lastidx_next;
        found_reg     <= found_next;
        flag_stat_reg <= flag_stat_next;
        out_byte_reg  <= out_byte_next;
        out_has_reg   <= out_has_next;
        out_last_reg  <= out_last_next;
        out_stat_reg  <= out_stat_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_stat_reg, out_has_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule
